### rtl/core/tlms_pkg.sv
// Shared constants, codes and the command type of the text line marquee scroller.
`timescale 1ns / 1ps
`default_nettype none
package tlms_pkg;

	localparam int LINES    = 4;
	localparam int COLUMNS  = 21;
	localparam int MAX_TEXT = 1024;

	localparam int LN_W   = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int POS_W  = $clog2(MAX_TEXT);
	localparam int LEN_W  = $clog2(MAX_TEXT + 1);
	localparam int PTR_W  = $clog2(MAX_TEXT + 2);
	localparam int ADDR_W = $clog2(LINES * MAX_TEXT);
	localparam int CNT_W  = $clog2(COLUMNS);
	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_ERASE = 2'd1;
	localparam logic [1:0] OP_POLL  = 2'd2;

	localparam logic [1:0] K_LOAD   = 2'd0;
	localparam logic [1:0] K_COMMIT = 2'd1;
	localparam logic [1:0] K_ERASE  = 2'd2;
	localparam logic [1:0] K_POLL   = 2'd3;

	localparam logic [1:0] MODE_L2R = 2'd1;
	localparam logic [1:0] MODE_R2L = 2'd2;

	localparam logic        REG_ROLL_IDX = 1'b0;
	localparam logic [15:0] ROLL_RESET   = 16'd500;

	typedef struct packed {
		logic [1:0]      kind;
		logic [LN_W-1:0] line;
		logic [7:0]      text_byte;
		logic            empty_text;
		logic [1:0]      roll_mode;
		logic [31:0]     now_ms;
	} cmd_t;

endpackage
`default_nettype wire

### rtl/core/tlms_front.sv
// Front end: takes items, drops the ignored ones and classifies the rest into commands.
`timescale 1ns / 1ps
`default_nettype none
module tlms_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic [1:0]    op,
	input  wire logic [1:0]    line,
	input  wire logic [7:0]    text_byte,
	input  wire logic          text_last,
	input  wire logic          empty_text,
	input  wire logic [1:0]    roll_mode,
	input  wire logic [31:0]   now_ms,
	input  wire logic          q_full,
	output logic               q_push,
	output tlms_pkg::cmd_t     q_data
);

	logic           v_s1;
	tlms_pkg::cmd_t cmd_s1;
	logic           keep;
	tlms_pkg::cmd_t cmd_nx;

	always_comb begin
		keep = (32'(line) < tlms_pkg::LINES);
		cmd_nx.line       = tlms_pkg::LN_W'(line);
		cmd_nx.text_byte  = text_byte;
		cmd_nx.empty_text = empty_text;
		cmd_nx.roll_mode  = roll_mode;
		cmd_nx.now_ms     = now_ms;
		unique case (op)
			tlms_pkg::OP_LOAD:  cmd_nx.kind = text_last ? tlms_pkg::K_COMMIT : tlms_pkg::K_LOAD;
			tlms_pkg::OP_ERASE: cmd_nx.kind = tlms_pkg::K_ERASE;
			tlms_pkg::OP_POLL:  cmd_nx.kind = tlms_pkg::K_POLL;
			default: begin
				cmd_nx.kind = tlms_pkg::K_LOAD;
				keep = 1'b0;
			end
		endcase
	end

	assign busy   = v_s1 && q_full;
	assign q_push = v_s1 && !q_full;
	assign q_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!busy) begin
			v_s1 <= start && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && start) begin
			cmd_s1 <= cmd_nx;
		end
	end

endmodule
`default_nettype wire

### rtl/core/tlms_queue.sv
// Command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module tlms_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  tlms_pkg::cmd_t      push_data,
	output logic                full,
	output logic                valid,
	output tlms_pkg::cmd_t      head,
	input  wire logic           pop
);

	tlms_pkg::cmd_t                entries_q [tlms_pkg::QDEPTH];
	logic [tlms_pkg::QA_W-1:0]     wr_ptr_q;
	logic [tlms_pkg::QA_W-1:0]     rd_ptr_q;
	logic [tlms_pkg::QA_W:0]       count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (count_q == (tlms_pkg::QA_W + 1)'(tlms_pkg::QDEPTH));
	assign valid   = (count_q != '0);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

### rtl/core/tlms_back.sv
// Back end: text store, per-line state, padding sweep, window walk and head step.
`timescale 1ns / 1ps
`default_nettype none
module tlms_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  tlms_pkg::cmd_t      q_head,
	output logic                q_pop,
	input  wire logic [15:0]    roll_interval,
	output logic                strobe,
	output logic [1:0]          out_line,
	output logic [4:0]          column,
	output logic [7:0]          char_byte,
	output logic                last
);

	localparam int LN_W   = tlms_pkg::LN_W;
	localparam int POS_W  = tlms_pkg::POS_W;
	localparam int LEN_W  = tlms_pkg::LEN_W;
	localparam int PTR_W  = tlms_pkg::PTR_W;
	localparam int ADDR_W = tlms_pkg::ADDR_W;
	localparam int CNT_W  = tlms_pkg::CNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_BRD  = 3'd3;
	localparam logic [2:0] ST_BFIN = 3'd4;

	localparam logic [7:0] SPACE = 8'h20;

	localparam logic [1:0] MODE_SEL_L2R = tlms_pkg::MODE_L2R;
	localparam logic [1:0] MODE_SEL_R2L = tlms_pkg::MODE_R2L;

	function automatic logic [ADDR_W-1:0] store_addr(input logic [LN_W-1:0] ln,
			input logic [POS_W-1:0] pos);
		return ADDR_W'(int'(ln) * tlms_pkg::MAX_TEXT) + ADDR_W'(pos);
	endfunction

	function automatic logic [POS_W-1:0] step_fwd(input logic [POS_W-1:0] pos,
			input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		r = LEN_W'(pos) + 1'b1;
		return (r >= len) ? '0 : POS_W'(r);
	endfunction

	function automatic logic [POS_W-1:0] step_back(input logic [POS_W-1:0] pos,
			input logic [LEN_W-1:0] len);
		return (pos == '0 || LEN_W'(pos) > len) ? POS_W'(len - 1'b1) : pos - 1'b1;
	endfunction

	logic [7:0]        mem [tlms_pkg::LINES * tlms_pkg::MAX_TEXT];
	logic [7:0]        rdata_q;

	logic [LEN_W-1:0]  len_q  [tlms_pkg::LINES];
	logic [POS_W-1:0]  head_q [tlms_pkg::LINES];
	logic [1:0]        mode_q [tlms_pkg::LINES];
	logic [31:0]       due_q  [tlms_pkg::LINES];
	logic [PTR_W-1:0]  ptr_q;

	logic [2:0]        state_q;
	logic [LN_W-1:0]   ln_q;
	logic [POS_W-1:0]  pad_pos_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  start_q;
	logic [LEN_W-1:0]  plen_q;
	logic [1:0]        pmode_q;
	logic [31:0]       due_nx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              first_lead_q;
	logic              trail_q;
	logic              rvld_s1;
	logic [CNT_W-1:0]  col_s1;

	logic              strobe_q;
	logic [LN_W-1:0]   oline_q;
	logic [CNT_W-1:0]  ocol_q;
	logic [7:0]        obyte_q;
	logic              olast_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	logic              is_load;
	logic              do_wr;
	logic [PTR_W-1:0]  ptr_nx;
	logic [PTR_W-1:0]  n_len;
	logic [LEN_W-1:0]  h_len;
	logic [POS_W-1:0]  h_pos0;
	logic              poll_go;
	logic [POS_W-1:0]  p_back;
	logic [POS_W-1:0]  p_fwd;
	logic [POS_W-1:0]  new_head;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		is_load = q_pop && (q_head.kind == tlms_pkg::K_LOAD || q_head.kind == tlms_pkg::K_COMMIT);
		do_wr   = !(q_head.kind == tlms_pkg::K_COMMIT && q_head.empty_text);
		ptr_nx  = (do_wr && ptr_q <= PTR_W'(tlms_pkg::MAX_TEXT)) ? ptr_q + 1'b1 : ptr_q;
		n_len   = q_head.empty_text ? '0 : ptr_nx;
		h_len   = len_q[q_head.line];
		h_pos0  = (LEN_W'(head_q[q_head.line]) >= h_len) ? '0 : head_q[q_head.line];
		poll_go = (h_len != '0) && (q_head.now_ms > due_q[q_head.line]);
		p_back  = step_back(start_q, plen_q);
		p_fwd   = first_lead_q ? step_fwd(start_q, plen_q) : start_q;
		case (pmode_q)
			MODE_SEL_L2R: new_head = rdata_q[7] ? step_back(p_back, plen_q) : p_back;
			MODE_SEL_R2L: new_head = step_fwd(p_fwd, plen_q);
			default:      new_head = start_q;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = store_addr(q_head.line, ptr_q[POS_W-1:0]);
		wdata = q_head.text_byte;
		re    = 1'b0;
		raddr = store_addr(ln_q, pos_q);
		unique case (state_q)
			ST_IDLE: we = is_load && do_wr && (ptr_q < PTR_W'(tlms_pkg::MAX_TEXT));
			ST_PAD: begin
				we    = 1'b1;
				waddr = store_addr(ln_q, pad_pos_q);
				wdata = SPACE;
			end
			ST_WALK: re = 1'b1;
			ST_BRD: begin
				re    = 1'b1;
				raddr = store_addr(ln_q, p_back);
			end
			ST_BFIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			rvld_s1 <= 1'b0;
			for (int i = 0; i < tlms_pkg::LINES; i++) begin
				len_q[i]  <= '0;
				head_q[i] <= '0;
				mode_q[i] <= '0;
				due_q[i]  <= '0;
			end
		end else begin
			rvld_s1 <= (state_q == ST_WALK);
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						ln_q <= q_head.line;
						unique case (q_head.kind)
							tlms_pkg::K_LOAD: ptr_q <= ptr_nx;
							tlms_pkg::K_COMMIT: begin
								ptr_q <= '0;
								if (n_len > PTR_W'(tlms_pkg::MAX_TEXT)) begin
									len_q[q_head.line] <= '0;
								end else begin
									mode_q[q_head.line] <= q_head.roll_mode;
									head_q[q_head.line] <= '0;
									due_q[q_head.line]  <= '0;
									if (n_len < PTR_W'(tlms_pkg::COLUMNS)) begin
										len_q[q_head.line] <= LEN_W'(tlms_pkg::COLUMNS);
										pad_pos_q <= POS_W'(n_len);
										state_q   <= ST_PAD;
									end else begin
										len_q[q_head.line] <= LEN_W'(n_len);
									end
								end
							end
							tlms_pkg::K_ERASE: len_q[q_head.line] <= '0;
							tlms_pkg::K_POLL: begin
								if (poll_go) begin
									start_q  <= h_pos0;
									pos_q    <= h_pos0;
									plen_q   <= h_len;
									pmode_q  <= mode_q[q_head.line];
									due_nx_q <= q_head.now_ms + 32'(roll_interval);
									cnt_q    <= '0;
									state_q  <= ST_WALK;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PAD: begin
					pad_pos_q <= pad_pos_q + 1'b1;
					if (pad_pos_q == POS_W'(tlms_pkg::COLUMNS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					pos_q   <= step_fwd(pos_q, plen_q);
					col_s1  <= cnt_q;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(tlms_pkg::COLUMNS - 1)) begin
						state_q <= ST_BRD;
					end
				end
				ST_BRD: state_q <= ST_BFIN;
				ST_BFIN: begin
					head_q[ln_q] <= new_head;
					due_q[ln_q]  <= due_nx_q;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output stage: a lead byte keeps its trail byte; a lead on the last column becomes a space
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			trail_q  <= 1'b0;
		end else begin
			strobe_q <= rvld_s1;
			if (rvld_s1) begin
				if (trail_q) begin
					trail_q <= 1'b0;
				end else if (rdata_q[7] && col_s1 != CNT_W'(tlms_pkg::COLUMNS - 1)) begin
					trail_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1) begin
			oline_q <= ln_q;
			ocol_q  <= col_s1;
			olast_q <= (col_s1 == CNT_W'(tlms_pkg::COLUMNS - 1));
			if (!trail_q && rdata_q[7] && col_s1 == CNT_W'(tlms_pkg::COLUMNS - 1)) begin
				obyte_q <= SPACE;
			end else begin
				obyte_q <= rdata_q;
			end
			if (col_s1 == '0) begin
				first_lead_q <= rdata_q[7];
			end
		end
	end

	assign strobe    = strobe_q;
	assign out_line  = 2'(oline_q);
	assign column    = 5'(ocol_q);
	assign char_byte = obyte_q;
	assign last      = olast_q;

endmodule
`default_nettype wire

### rtl/core/text_line_marquee_scroller.sv
// Top level of the text line marquee scroller: front end, command queue, back end, registers.
//
// Items enter on start when busy is low: loads, commits, erases and polls of one display line.
// The front end registers and classifies each item and queues it; items for lines out of
// range and unknown ops are dropped there. busy rises only when the four-entry queue is full.
// The back end works one command at a time, all through the single-port text store:
//   load byte, erase and poll not due: handled in the idle state alone;
//   commit: in the idle state, plus one padding space per cycle for texts shorter than the window;
//   poll due: COLUMNS window reads at one per cycle, then the head step in ST_BRD and ST_BFIN.
// A due poll's item passes the front-end register and the queue, then the store read and the
// output register; the window columns come out on consecutive cycles, each on the result ports for
// one cycle with strobe high, last marking the final column. The receiver cannot stall.
// The user writes roll_interval_ms on the APB port (address 0) only while the block is idle;
// the block itself does not enforce this. Reset empties all lines, zeroes heads, modes, due
// times and the load pointer, and sets the interval to 500; the text store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module text_line_marquee_scroller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [1:0]  line,
	input  wire logic [7:0]  text_byte,
	input  wire logic        text_last,
	input  wire logic        empty_text,
	input  wire logic [1:0]  roll_mode,
	input  wire logic [31:0] now_ms,
	output logic             strobe,
	output logic [1:0]       out_line,
	output logic [4:0]       column,
	output logic [7:0]       char_byte,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic           q_full;
	logic           q_push;
	tlms_pkg::cmd_t q_data;
	logic           q_valid;
	tlms_pkg::cmd_t q_head;
	logic           q_pop;
	logic [15:0]    interval_q;
	logic           reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == tlms_pkg::REG_ROLL_IDX) && (paddr[1:0] == 2'b00 || 1'b1);
	assign prdata  = reg_sel ? {16'b0, interval_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= tlms_pkg::ROLL_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			interval_q <= pwdata[15:0];
		end
	end

	tlms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.line       (line),
		.text_byte  (text_byte),
		.text_last  (text_last),
		.empty_text (empty_text),
		.roll_mode  (roll_mode),
		.now_ms     (now_ms),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	tlms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head),
		.pop       (q_pop)
	);

	tlms_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.roll_interval (interval_q),
		.strobe        (strobe),
		.out_line      (out_line),
		.column        (column),
		.char_byte     (char_byte),
		.last          (last)
	);

endmodule
`default_nettype wire

### test/tb_text_line_marquee_scroller.sv
// Testbench of the marquee scroller: directed and random items checked against a line model.
`timescale 1ns / 1ps
module tb_text_line_marquee_scroller;

	localparam logic [1:0] OP_NONE      = 2'd3;
	localparam logic [1:0] MODE_STATIC  = 2'd0;
	localparam logic [1:0] MODE_ODD     = 2'd3;
	localparam logic [2:0] ROLL_ADDR    = {tlms_pkg::REG_ROLL_IDX, 2'b00};
	localparam int         STORE_N      = tlms_pkg::LINES * tlms_pkg::MAX_TEXT;
	localparam int         SETTLE       = 150;
	localparam int         LIMIT_CYCLES = 1000000;

	typedef struct {
		logic [1:0]  op;
		logic [1:0]  ln;
		logic [7:0]  tb;
		logic        tl;
		logic        et;
		logic [1:0]  rm;
		logic [31:0] now;
	} item_t;

	typedef struct packed {
		logic [1:0] ln;
		logic [4:0] col;
		logic [7:0] chr;
		logic       lst;
	} win_byte_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  op         = '0;
	logic [1:0]  line       = '0;
	logic [7:0]  text_byte  = '0;
	logic        text_last  = 1'b0;
	logic        empty_text = 1'b0;
	logic [1:0]  roll_mode  = '0;
	logic [31:0] now_ms     = '0;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic        busy;
	logic        strobe;
	logic [1:0]  out_line;
	logic [4:0]  column;
	logic [7:0]  char_byte;
	logic        last;
	logic [31:0] prdata;
	logic        pready;

	item_t       cmd_q[$];
	win_byte_t   window_q[$];
	item_t       cur_item;
	int          errors    = 0;
	int          idle_left = 0;
	bit          no_idle   = 1'b0;

	// line model
	logic [7:0]  m_text [STORE_N];
	int unsigned m_len  [tlms_pkg::LINES];
	int unsigned m_head [tlms_pkg::LINES];
	logic [1:0]  m_mode [tlms_pkg::LINES];
	logic [31:0] m_due  [tlms_pkg::LINES];
	int unsigned m_ptr;
	logic [15:0] m_roll;

	// stimulus side: which store bytes hold data, so no unwritten byte is ever shown
	bit          g_written [STORE_N];
	int unsigned g_ptr    = 0;
	logic [31:0] g_now    = '0;
	logic [15:0] g_roll   = tlms_pkg::ROLL_RESET;
	int          g_count  = 0;
	logic [1:0]  g_recent = '0;

	text_line_marquee_scroller dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .line(line), .text_byte(text_byte), .text_last(text_last),
		.empty_text(empty_text), .roll_mode(roll_mode), .now_ms(now_ms),
		.strobe(strobe), .out_line(out_line), .column(column), .char_byte(char_byte),
		.last(last), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned next_pos(int unsigned p, int unsigned len);
		return (p + 1 >= len) ? 0 : p + 1;
	endfunction

	function automatic int unsigned prev_pos(int unsigned p, int unsigned len);
		return (p == 0 || p > len) ? len - 1 : p - 1;
	endfunction

	task automatic queue_byte(input logic [1:0] l, input int unsigned col, input logic [7:0] b);
		win_byte_t w;
		w.ln  = l;
		w.col = col[4:0];
		w.chr = b;
		w.lst = (col == tlms_pkg::COLUMNS - 1);
		window_q.push_back(w);
	endtask

	task automatic shadow_apply(input item_t it);
		int unsigned n;
		int unsigned pos;
		int unsigned col;
		int unsigned len;
		int unsigned base;
		logic [7:0]  c;
		base = it.ln * tlms_pkg::MAX_TEXT;
		case (it.op)
			tlms_pkg::OP_LOAD: begin
				if (!(it.tl && it.et)) begin
					if (m_ptr < tlms_pkg::MAX_TEXT)
						m_text[base + m_ptr] = it.tb;
					if (m_ptr <= tlms_pkg::MAX_TEXT)
						m_ptr++;
				end
				if (it.tl) begin
					n = it.et ? 0 : m_ptr;
					m_ptr = 0;
					if (n > tlms_pkg::MAX_TEXT) begin
						m_len[it.ln] = 0;
					end else begin
						while (n < tlms_pkg::COLUMNS) begin
							m_text[base + n] = 8'h20;
							n++;
						end
						m_len[it.ln]  = n;
						m_mode[it.ln] = it.rm;
						m_head[it.ln] = 0;
						m_due[it.ln]  = '0;
					end
				end
			end
			tlms_pkg::OP_ERASE: m_len[it.ln] = 0;
			tlms_pkg::OP_POLL: begin
				len = m_len[it.ln];
				if (len != 0 && it.now > m_due[it.ln]) begin
					pos = (m_head[it.ln] >= len) ? 0 : m_head[it.ln];
					col = 0;
					while (col < tlms_pkg::COLUMNS) begin
						c = m_text[base + pos];
						if (c >= 8'h80 && tlms_pkg::COLUMNS - col >= 2) begin
							queue_byte(it.ln, col, c);
							pos = next_pos(pos, len);
							queue_byte(it.ln, col + 1, m_text[base + pos]);
							pos = next_pos(pos, len);
							col += 2;
						end else if (c >= 8'h80) begin
							// lead byte on the last column: blank
							queue_byte(it.ln, col, 8'h20);
							col++;
						end else begin
							queue_byte(it.ln, col, c);
							pos = next_pos(pos, len);
							col++;
						end
					end
					pos = (m_head[it.ln] >= len) ? 0 : m_head[it.ln];
					if (m_mode[it.ln] == tlms_pkg::MODE_L2R) begin
						pos = prev_pos(pos, len);
						if (m_text[base + pos] >= 8'h80)
							pos = prev_pos(pos, len);
					end else if (m_mode[it.ln] == tlms_pkg::MODE_R2L) begin
						if (m_text[base + pos] >= 8'h80)
							pos = next_pos(pos, len);
						pos = next_pos(pos, len);
					end
					m_head[it.ln] = pos;
					m_due[it.ln]  = it.now + m_roll;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : driver
		logic hold;
		logic send;
		hold = start && busy;
		send = 1'b0;
		if (start && !busy)
			shadow_apply(cur_item);
		if (!hold) begin
			if (idle_left > 0) begin
				idle_left--;
			end else if (cmd_q.size() != 0) begin
				if (!no_idle && $urandom_range(0, 99) < 10)
					idle_left = $urandom_range(0, 13);
				else
					send = 1'b1;
			end
			if (send) begin
				cur_item = cmd_q.pop_front();
				op         <= cur_item.op;
				line       <= cur_item.ln;
				text_byte  <= cur_item.tb;
				text_last  <= cur_item.tl;
				empty_text <= cur_item.et;
				roll_mode  <= cur_item.rm;
				now_ms     <= cur_item.now;
			end
			start <= send;
		end
	end

	always @(posedge clk) begin : monitor
		win_byte_t got;
		win_byte_t want;
		if (arst_n && strobe === 1'b1) begin
			got = {out_line, column, char_byte, last};
			if (window_q.size() == 0) begin
				errors++;
				$display("%t unexpected byte: line %0d col %0d byte %h last %b",
					$time, got.ln, got.col, got.chr, got.lst);
			end else begin
				want = window_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%t mismatch: expected line %0d col %0d byte %h last %b,",
						$time, want.ln, want.col, want.chr, want.lst,
						" actual line %0d col %0d byte %h last %b",
						got.ln, got.col, got.chr, got.lst);
				end
			end
		end
	end

	task automatic apb_xfer(input logic wr, input logic [2:0] a, input logic [31:0] d,
			output logic [31:0] q);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		q = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_roll(input logic [15:0] v);
		logic [31:0] q;
		apb_xfer(1'b1, ROLL_ADDR, {16'd0, v}, q);
		m_roll = v;
		g_roll = v;
		apb_xfer(1'b0, ROLL_ADDR, '0, q);
		if (q !== {16'd0, v}) begin
			errors++;
			$display("%t roll interval readback: expected %h actual %h", $time, {16'd0, v}, q);
		end
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		while (cmd_q.size() != 0 || start || window_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic push_item(input logic [1:0] o, l, input logic [7:0] b, input logic tl, et,
			input logic [1:0] rm, input logic [31:0] t);
		item_t       it;
		int unsigned n;
		it = '{o, l, b, tl, et, rm, t};
		if (o == tlms_pkg::OP_LOAD) begin
			if (!(tl && et)) begin
				if (g_ptr < tlms_pkg::MAX_TEXT)
					g_written[l * tlms_pkg::MAX_TEXT + g_ptr] = 1'b1;
				if (g_ptr <= tlms_pkg::MAX_TEXT)
					g_ptr++;
			end
			if (tl) begin
				n = et ? 0 : g_ptr;
				g_ptr = 0;
				if (n <= tlms_pkg::MAX_TEXT) begin
					while (n < tlms_pkg::COLUMNS) begin
						g_written[l * tlms_pkg::MAX_TEXT + n] = 1'b1;
						n++;
					end
				end
			end
		end
		if (o != OP_NONE)
			g_count++;
		cmd_q.push_back(it);
	endtask

	function automatic logic [7:0] rand_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 8'($urandom_range(128, 255));
		if (r < 42)
			return 8'h20;
		return 8'($urandom_range(0, 127));
	endfunction

	task automatic gen_poll(input logic [1:0] l);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			g_now = $urandom();
		else if (r < 88)
			g_now = g_now + $urandom_range(0, 2 * g_roll + 20);
		push_item(tlms_pkg::OP_POLL, l, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), g_now);
	endtask

	// k bytes without the last mark, then the committing byte (discarded when empty)
	task automatic gen_text(input logic [1:0] l, input int k, input logic empty,
			input logic [1:0] mode);
		logic [1:0] dst;
		for (int i = 0; i < k; i++) begin
			dst = l;
			// a byte may stray to another line where this line's byte is already held
			if (k < 64 && $urandom_range(0, 99) < 10 && g_ptr < tlms_pkg::MAX_TEXT
					&& g_written[l * tlms_pkg::MAX_TEXT + g_ptr])
				dst = 2'($urandom_range(0, tlms_pkg::LINES - 1));
			if (k < 64 && $urandom_range(0, 99) < 6) begin
				if ($urandom_range(0, 1))
					gen_poll(2'($urandom_range(0, tlms_pkg::LINES - 1)));
				else
					push_item(tlms_pkg::OP_ERASE, 2'($urandom_range(0, tlms_pkg::LINES - 1)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom());
			end
			push_item(tlms_pkg::OP_LOAD, dst, rand_text_byte(), 1'b0, 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)), $urandom());
		end
		push_item(tlms_pkg::OP_LOAD, l, rand_text_byte(), 1'b1, empty, mode, $urandom());
		g_recent = l;
	endtask

	task automatic random_phase(input int quota);
		int         stop;
		int         sel;
		int         r;
		logic [1:0] l;
		stop = g_count + quota;
		while (g_count < stop) begin
			sel = $urandom_range(0, 99);
			l   = 2'($urandom_range(0, tlms_pkg::LINES - 1));
			if (sel < 40) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					gen_text(l, $urandom_range(0, 4), 1'b1, 2'($urandom_range(0, 3)));
				else if (r < 40)
					gen_text(l, $urandom_range(0, 19), 1'b0, 2'($urandom_range(0, 3)));
				else
					gen_text(l, $urandom_range(20, 44), 1'b0, 2'($urandom_range(0, 3)));
				repeat ($urandom_range(1, 3)) gen_poll(l);
			end else if (sel < 85) begin
				repeat ($urandom_range(1, 4))
					gen_poll(($urandom_range(0, 99) < 60) ? g_recent
						: 2'($urandom_range(0, 3)));
			end else if (sel < 94) begin
				push_item(tlms_pkg::OP_ERASE, l, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					2'($urandom_range(0, 3)), $urandom());
			end else begin
				push_item(OP_NONE, l, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom());
			end
		end
	endtask

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("FAIL text_line_marquee_scroller");
		$finish;
	end

	initial begin : run
		logic [31:0] q;
		for (int i = 0; i < STORE_N; i++) begin
			m_text[i]    = '0;
			g_written[i] = 1'b0;
		end
		for (int i = 0; i < tlms_pkg::LINES; i++) begin
			m_len[i]  = 0;
			m_head[i] = 0;
			m_mode[i] = MODE_STATIC;
			m_due[i]  = '0;
		end
		m_ptr  = 0;
		m_roll = tlms_pkg::ROLL_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_xfer(1'b0, ROLL_ADDR, '0, q);
		if (q !== {16'd0, tlms_pkg::ROLL_RESET}) begin
			errors++;
			$display("%t roll interval after reset: expected %h actual %h",
				$time, {16'd0, tlms_pkg::ROLL_RESET}, q);
		end

		// directed
		push_item(tlms_pkg::OP_POLL, 2'd0, 8'hFF, 1'b1, 1'b1, MODE_ODD, 32'hFFFF_FFFF);
		push_item(tlms_pkg::OP_LOAD, 2'd1, 8'hFF, 1'b1, 1'b1, MODE_ODD, 32'd0);
		push_item(tlms_pkg::OP_POLL, 2'd1, 8'h00, 1'b0, 1'b0, MODE_STATIC, 32'd0);
		push_item(tlms_pkg::OP_POLL, 2'd1, 8'h00, 1'b0, 1'b0, MODE_STATIC, 32'hFFFF_FFFF);
		push_item(tlms_pkg::OP_POLL, 2'd1, 8'h00, 1'b0, 1'b0, MODE_STATIC, 32'd400);
		push_item(OP_NONE, 2'd2, 8'h41, 1'b1, 1'b0, tlms_pkg::MODE_L2R, 32'd7);
		for (int i = 0; i < 20; i++)
			push_item(tlms_pkg::OP_LOAD, 2'd0,
				(i == 0) ? 8'h00 : (i == 1) ? 8'h7F : 8'(8'h41 + i),
				1'b0, 1'b0, MODE_STATIC, 32'd0);
		// lead byte lands on the last column
		push_item(tlms_pkg::OP_LOAD, 2'd0, 8'hFF, 1'b1, 1'b0, tlms_pkg::MODE_R2L, 32'd0);
		push_item(tlms_pkg::OP_POLL, 2'd0, 8'h00, 1'b0, 1'b0, MODE_STATIC, 32'd1);
		push_item(tlms_pkg::OP_POLL, 2'd0, 8'h00, 1'b0, 1'b0, MODE_STATIC, 32'd1000);
		push_item(tlms_pkg::OP_LOAD, 2'd3, 8'h80, 1'b1, 1'b0, tlms_pkg::MODE_L2R, 32'd0);
		push_item(tlms_pkg::OP_POLL, 2'd3, 8'h00, 1'b0, 1'b0, MODE_STATIC, 32'd2);
		push_item(tlms_pkg::OP_ERASE, 2'd0, 8'h00, 1'b0, 1'b0, MODE_STATIC, 32'd0);
		push_item(tlms_pkg::OP_POLL, 2'd0, 8'h00, 1'b0, 1'b0, MODE_STATIC, 32'hFFFF_FFFF);
		g_now = 32'd1000;
		wait_quiet();

		set_roll(16'd0);
		random_phase(50);
		wait_quiet();

		set_roll(16'hFFFF);
		random_phase(50);
		wait_quiet();

		set_roll(16'($urandom_range(1, 3000)));
		random_phase(50);
		wait_quiet();

		set_roll(16'($urandom_range(0, 65535)));
		no_idle = 1'b1;
		random_phase(50);
		wait_quiet();

		if (errors == 0)
			$display("PASS text_line_marquee_scroller");
		else
			$display("FAIL text_line_marquee_scroller");
		$finish;
	end

endmodule

### filelist.f
rtl/core/tlms_pkg.sv
rtl/core/tlms_front.sv
rtl/core/tlms_queue.sv
rtl/core/tlms_back.sv
rtl/core/text_line_marquee_scroller.sv
test/tb_text_line_marquee_scroller.sv
